// ===== rtl/ckt_pkg.sv =====
// Shared types and codes for the compacting keyed table.
// Used by ckt_cell and compacting_keyed_table; no dependencies.
`default_nettype none

package ckt_pkg;

   localparam int KEY_W = 16;
   localparam int PAY_W = 16;
   localparam int OP_W  = 2;
   localparam int FILL_W = 5;

   localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_FIND   = 2'd2;

   localparam logic ST_OK   = 1'b0;
   localparam logic ST_FAIL = 1'b1;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [KEY_W-1:0] key;
      logic [PAY_W-1:0] payload;
   } req_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [PAY_W-1:0] payload;
   } entry_type;

   // Passed up the row: any match so far, payload of the first match.
   typedef struct packed {
      logic             hit;
      logic [PAY_W-1:0] payload;
   } chain_type;

   // Per-cell control from the top level.
   typedef struct packed {
      logic fire;
      logic occupied;
      logic add_sel;
   } cell_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/ckt_cell.sv =====
// One slot of the table: holds a key and payload, compares against the request,
// forwards the first-match chain and loads its upper neighbor on remove. Uses ckt_pkg.
`default_nettype none

module ckt_cell
   import ckt_pkg::*;
(
   input  wire          clock,
   input  req_type      req,
   input  cell_ctl_type ctl,
   input  entry_type    upper,
   input  chain_type    chain_in,
   output chain_type    chain_out,
   output entry_type    entry
);

   entry_type entry_ff;
   entry_type entry_in;
   logic      match;
   logic      first;

   assign match = ctl.occupied && (entry_ff.key == req.key);
   assign first = match && !chain_in.hit;

   always_comb begin
      chain_out.hit     = chain_in.hit | match;
      chain_out.payload = chain_in.payload | (first ? entry_ff.payload : '0);
   end

   always_comb begin
      entry_in = entry_ff;
      if (ctl.fire) begin
         if (req.op == OP_ADD && ctl.add_sel) begin
            entry_in.key     = req.key;
            entry_in.payload = req.payload;
         end else if (req.op == OP_REMOVE && (chain_in.hit || match)) begin
            // close the gap: take the neighbor's entry
            entry_in = upper;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

// ===== rtl/compacting_keyed_table.sv =====
// Compacting keyed table: a row of CAPACITY cells holding (key, payload)
// entries packed in arrival order. Uses ckt_pkg and ckt_cell.
//
// Usage:
//   req_ channel carries one operation per beat: tuser is the operation
//   (add, remove by key, find by key), tdata holds key and payload.
//   rsp_ channel returns exactly one beat per request: tuser is the status
//   (0 success, 1 full, not found or bad operation), tdata holds the found
//   payload and the fill count after the operation.
//   A request is registered first. One request per cycle is sustained while
//   rsp_tready is high: the whole cell row compares, picks the first match
//   through the neighbor chain and shifts down in the same cycle.
//   The response sits in an output register; while it waits, one more
//   request is taken and held, and the input stalls only when both are full.
//   Reset empties the table (fill count 0) and drops any held beat; entry
//   contents are left as they are and are only read below the fill count.
`default_nettype none

module compacting_keyed_table
   import ckt_pkg::*;
#(
   parameter int CAPACITY = 16
)(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,   // [15:0] key, [31:16] payload
   input  wire  [1:0]  req_tuser,   // [1:0] operation
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [23:0] rsp_tdata,   // [15:0] found_payload, [20:16] fill_count, [23:21] zero
   output logic        rsp_tuser    // [0] status
);

   localparam int CW = $clog2(CAPACITY + 1);

   logic            busy_ff, busy_in;
   req_type         req_ff, req_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            status_ff, status_in;
   logic [PAY_W-1:0] found_ff, found_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   logic            out_free;
   logic            fire;
   logic            not_full;
   chain_type       chain [CAPACITY+1];
   entry_type       entries [CAPACITY+1];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign fire       = busy_ff && out_free;
   assign req_tready = !busy_ff || fire;
   assign not_full   = (count_ff < CW'(CAPACITY));

   assign chain[0]         = '0;
   assign entries[CAPACITY] = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      cell_ctl_type ctl;
      always_comb begin
         ctl.fire     = fire;
         ctl.occupied = (CW'(i) < count_ff);
         ctl.add_sel  = (CW'(i) == count_ff);
      end
      ckt_cell u_cell (
         .clock     (clock),
         .req       (req_ff),
         .ctl       (ctl),
         .upper     (entries[i+1]),
         .chain_in  (chain[i]),
         .chain_out (chain[i+1]),
         .entry     (entries[i])
      );
   end

   always_comb begin
      busy_in = busy_ff;
      req_in  = req_ff;
      if (fire) busy_in = 1'b0;
      if (req_tvalid && req_tready) begin
         busy_in        = 1'b1;
         req_in.op      = req_tuser;
         req_in.key     = req_tdata[15:0];
         req_in.payload = req_tdata[31:16];
      end
   end

   always_comb begin
      count_in     = count_ff;
      status_in    = ST_FAIL;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      found_in     = found_ff;
      fill_in      = fill_ff;
      if (fire) begin
         unique case (req_ff.op)
            OP_ADD: begin
               if (not_full) begin
                  count_in  = count_ff + CW'(1);
                  status_in = ST_OK;
               end
            end
            OP_REMOVE: begin
               if (chain[CAPACITY].hit) begin
                  count_in  = count_ff - CW'(1);
                  status_in = ST_OK;
               end
            end
            OP_FIND: begin
               if (chain[CAPACITY].hit) status_in = ST_OK;
            end
            default: status_in = ST_FAIL;
         endcase
         rsp_valid_in = 1'b1;
         found_in     = (req_ff.op == OP_FIND && chain[CAPACITY].hit) ?
                        chain[CAPACITY].payload : '0;
         fill_in      = FILL_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      if (fire) begin
         status_ff <= status_in;
         found_ff  <= found_in;
         fill_ff   <= fill_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {3'b000, fill_ff, found_ff};

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("fill count above capacity");

   a_add_grows: assert property (@(posedge clock) disable iff (reset)
      fire && req_ff.op == OP_ADD && not_full |=> count_ff == $past(count_ff) + CW'(1))
      else $error("successful add did not grow the table");

   a_fail_no_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == ST_FAIL |-> found_ff == '0)
      else $error("failed operation returned a payload");

   a_fire_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("executed request produced no response");

endmodule

`default_nettype wire
